@@ design/pfe_pkg.sv @@
// Package for the Playfair digraph encryptor: constants, codes, command and
// status structs, and the letter helpers. No dependencies.
`default_nettype none

package pfe_pkg;

  localparam int unsigned SQUARE_SIDE = 5;
  localparam int unsigned CELLS       = SQUARE_SIDE * SQUARE_SIDE;
  localparam int unsigned NUM_LETTERS = 26;

  typedef logic [4:0] letter_t;
  typedef logic [4:0] cell_t;
  typedef logic [2:0] coord_t;

  typedef struct packed {
    coord_t row;
    coord_t col;
  } pos_t;

  typedef struct packed {
    logic    ok;
    letter_t idx;
  } dec_t;

  localparam letter_t LETTER_I    = 5'd8;
  localparam letter_t LETTER_J    = 5'd9;
  localparam letter_t LETTER_X    = 5'd23;
  localparam letter_t LETTER_LAST = letter_t'(NUM_LETTERS - 1);

  localparam logic [7:0] ASCII_A    = 8'h41;
  localparam logic [7:0] ASCII_Z    = 8'h5a;
  localparam logic [7:0] ASCII_LC_A = 8'h61;
  localparam logic [7:0] ASCII_LC_Z = 8'h7a;
  localparam logic [7:0] ASCII_CASE = 8'h20;

  typedef enum logic [1:0] {
    OP_KEY      = 2'd0,
    OP_KEY_DONE = 2'd1,
    OP_TEXT     = 2'd2,
    OP_END      = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FILL,
    ST_POS_B,
    ST_POS_WAIT,
    ST_CALC,
    ST_SQ_A,
    ST_OUT_A,
    ST_SQ_B,
    ST_OUT_B
  } state_e;

  typedef struct packed {
    logic capture;
    logic place;
    logic fill_start;
    logic fill_next;
    logic key_set;
    logic held_load;
    logic held_clear;
    logic partner_load;
    logic partner_x;
    logic pos_sel_b;
    logic pos_a_cap;
    logic pos_b_cap;
    logic calc;
    logic sq_sel_b;
    logic out_load;
    logic out_last;
  } ctrl_cmd_t;

  typedef struct packed {
    op_e  op;
    logic letter_ok;
    logic key_ready;
    logic held_valid;
    logic same_letter;
    logic place_ok;
    logic fill_done;
    logic out_free;
  } ctrl_sts_t;

  function automatic dec_t decode_letter(logic [7:0] ch);
    logic [7:0] up;
    dec_t       d;
    up    = (ch >= ASCII_LC_A && ch <= ASCII_LC_Z) ? ch - ASCII_CASE : ch;
    d.ok  = (up >= ASCII_A) && (up <= ASCII_Z);
    d.idx = letter_t'(up - ASCII_A);
    if (d.idx == LETTER_J) begin
      d.idx = LETTER_I;
    end
    return d;
  endfunction

  function automatic cell_t cell_of(pos_t p);
    return cell_t'(cell_t'(p.row) * cell_t'(SQUARE_SIDE) + cell_t'(p.col));
  endfunction

  function automatic coord_t coord_inc(coord_t c);
    return (c == coord_t'(SQUARE_SIDE - 1)) ? coord_t'(0) : coord_t'(c + coord_t'(1));
  endfunction

endpackage

`default_nettype wire

@@ design/pfe_in_if.sv @@
// Input channel of the encryptor: valid/ready plus op and byte.
// Depends on pfe_pkg.
`default_nettype none

interface pfe_in_if;
  logic          valid;
  logic          ready;
  pfe_pkg::op_e  op;
  logic [7:0]    char_in;

  modport source (output valid, output op, output char_in, input ready);
  modport sink   (input valid, input op, input char_in, output ready);
endinterface

`default_nettype wire

@@ design/pfe_out_if.sv @@
// Output channel of the encryptor: valid/ready plus cipher letter and last flag.
// No dependencies.
`default_nettype none

interface pfe_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] cipher_char;
  logic       last;

  modport source (output valid, output cipher_char, output last, input ready);
  modport sink   (input valid, input cipher_char, input last, output ready);
endinterface

`default_nettype wire

@@ design/pfe_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pfe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ design/pfe_controller.sv @@
// Sequencer of the encryptor: decodes each beat and steps the datapath.
// Depends on pfe_pkg.
`default_nettype none

module pfe_controller (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  pfe_pkg::ctrl_sts_t sts_i,
  output logic               in_ready_o,
  output pfe_pkg::ctrl_cmd_t cmd_o
);
  import pfe_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_d = ST_IDLE;
        unique case (sts_i.op)
          OP_KEY: begin
            cmd_o.place = !sts_i.key_ready && sts_i.letter_ok && sts_i.place_ok;
          end
          OP_KEY_DONE: begin
            if (!sts_i.key_ready) begin
              cmd_o.fill_start = 1'b1;
              state_d          = ST_FILL;
            end
          end
          OP_TEXT: begin
            if (sts_i.key_ready && sts_i.letter_ok) begin
              if (!sts_i.held_valid) begin
                cmd_o.held_load = 1'b1;
              end else begin
                cmd_o.partner_load = 1'b1;
                cmd_o.partner_x    = sts_i.same_letter;
                cmd_o.held_clear   = !sts_i.same_letter;
                state_d            = ST_POS_B;
              end
            end
          end
          OP_END: begin
            if (sts_i.key_ready && sts_i.held_valid) begin
              cmd_o.partner_load = 1'b1;
              cmd_o.partner_x    = 1'b1;
              cmd_o.held_clear   = 1'b1;
              state_d            = ST_POS_B;
            end
          end
          default: ;
        endcase
      end
      ST_FILL: begin
        cmd_o.place = sts_i.place_ok;
        if (sts_i.fill_done) begin
          cmd_o.key_set = 1'b1;
          state_d       = ST_IDLE;
        end else begin
          cmd_o.fill_next = 1'b1;
        end
      end
      ST_POS_B: begin
        cmd_o.pos_sel_b = 1'b1;
        cmd_o.pos_a_cap = 1'b1;
        state_d         = ST_POS_WAIT;
      end
      ST_POS_WAIT: begin
        cmd_o.pos_b_cap = 1'b1;
        state_d         = ST_CALC;
      end
      ST_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = ST_SQ_A;
      end
      ST_SQ_A: begin
        state_d = ST_OUT_A;
      end
      ST_OUT_A: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_SQ_B;
        end
      end
      ST_SQ_B: begin
        cmd_o.sq_sel_b = 1'b1;
        state_d        = ST_OUT_B;
      end
      ST_OUT_B: begin
        cmd_o.sq_sel_b = 1'b1;
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ design/pfe_datapath.sv @@
// Datapath of the encryptor: key square and letter position RAMs, used flags,
// pairing registers, rule logic and the output register. Depends on pfe_pkg, pfe_ram.
`default_nettype none

module pfe_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pfe_pkg::op_e       op_i,
  input  logic [7:0]         char_in_i,
  input  logic               out_ready_i,
  input  pfe_pkg::ctrl_cmd_t cmd_i,
  output pfe_pkg::ctrl_sts_t sts_o,
  output logic               out_valid_o,
  output logic [6:0]         cipher_char_o,
  output logic               last_o
);
  import pfe_pkg::*;

  op_e                    op_q;
  letter_t                letter_q;
  logic                   letter_ok_q;
  letter_t                held_q;
  logic                   held_valid_q;
  letter_t                partner_q;
  logic                   key_ready_q;
  logic [NUM_LETTERS-1:0] used_q;
  coord_t                 fill_row_q;
  coord_t                 fill_col_q;
  pos_t                   pos_a_q;
  pos_t                   pos_b_q;
  cell_t                  o1_q;
  cell_t                  o2_q;
  logic                   out_valid_q;
  logic [6:0]             out_char_q;
  logic                   out_last_q;

  dec_t                   dec;
  pos_t                   o1_pos;
  pos_t                   o2_pos;
  logic [$bits(pos_t)-1:0] pos_rdata;
  letter_t                sq_rdata;
  letter_t                pos_raddr;
  cell_t                  sq_raddr;
  pos_t                   fill_pos;

  assign dec       = decode_letter(char_in_i);
  assign fill_pos  = '{row: fill_row_q, col: fill_col_q};
  assign pos_raddr = cmd_i.pos_sel_b ? partner_q : held_q;
  assign sq_raddr  = cmd_i.sq_sel_b ? o2_q : o1_q;

  pfe_ram #(.WIDTH($bits(pos_t)), .DEPTH(NUM_LETTERS)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.place),
    .waddr_i (letter_q),
    .wdata_i (fill_pos),
    .raddr_i (pos_raddr),
    .rdata_o (pos_rdata)
  );

  pfe_ram #(.WIDTH($bits(letter_t)), .DEPTH(CELLS)) u_sq_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.place),
    .waddr_i (cell_of(fill_pos)),
    .wdata_i (letter_q),
    .raddr_i (sq_raddr),
    .rdata_o (sq_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_ready_q  <= 1'b0;
      held_valid_q <= 1'b0;
      used_q       <= '0;
      fill_row_q   <= '0;
      fill_col_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.key_set) begin
        key_ready_q <= 1'b1;
      end
      if (cmd_i.held_load) begin
        held_valid_q <= 1'b1;
      end else if (cmd_i.held_clear) begin
        held_valid_q <= 1'b0;
      end
      if (cmd_i.place) begin
        used_q[letter_q] <= 1'b1;
        if (fill_col_q == coord_t'(SQUARE_SIDE - 1)) begin
          fill_col_q <= '0;
          fill_row_q <= coord_t'(fill_row_q + coord_t'(1));
        end else begin
          fill_col_q <= coord_t'(fill_col_q + coord_t'(1));
        end
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q        <= op_i;
      letter_q    <= dec.ok ? dec.idx : '0;
      letter_ok_q <= dec.ok;
    end else if (cmd_i.fill_start) begin
      letter_q <= '0;
    end else if (cmd_i.fill_next) begin
      letter_q <= letter_t'(letter_q + letter_t'(1));
    end
    if (cmd_i.held_load) begin
      held_q <= letter_q;
    end
    if (cmd_i.partner_load) begin
      partner_q <= cmd_i.partner_x ? LETTER_X : letter_q;
    end
    if (cmd_i.pos_a_cap) begin
      pos_a_q <= pos_t'(pos_rdata);
    end
    if (cmd_i.pos_b_cap) begin
      pos_b_q <= pos_t'(pos_rdata);
    end
    if (cmd_i.calc) begin
      o1_q <= cell_of(o1_pos);
      o2_q <= cell_of(o2_pos);
    end
    if (cmd_i.out_load) begin
      out_char_q <= 7'(ASCII_A) + 7'(sq_rdata);
      out_last_q <= cmd_i.out_last;
    end
  end

  always_comb begin
    priority if (pos_a_q.row == pos_b_q.row) begin
      o1_pos = '{row: pos_a_q.row, col: coord_inc(pos_a_q.col)};
      o2_pos = '{row: pos_b_q.row, col: coord_inc(pos_b_q.col)};
    end else if (pos_a_q.col == pos_b_q.col) begin
      o1_pos = '{row: coord_inc(pos_a_q.row), col: pos_a_q.col};
      o2_pos = '{row: coord_inc(pos_b_q.row), col: pos_b_q.col};
    end else begin
      o1_pos = '{row: pos_a_q.row, col: pos_b_q.col};
      o2_pos = '{row: pos_b_q.row, col: pos_a_q.col};
    end
  end

  always_comb begin
    sts_o             = '0;
    sts_o.op          = op_q;
    sts_o.letter_ok   = letter_ok_q;
    sts_o.key_ready   = key_ready_q;
    sts_o.held_valid  = held_valid_q;
    sts_o.same_letter = (letter_q == held_q);
    sts_o.place_ok    = (letter_q <= LETTER_LAST) && !used_q[letter_q]
                        && (letter_q != LETTER_J)
                        && (fill_row_q != coord_t'(SQUARE_SIDE));
    sts_o.fill_done   = (letter_q == LETTER_LAST);
    sts_o.out_free    = !out_valid_q || out_ready_i;
  end

  assign out_valid_o   = out_valid_q;
  assign cipher_char_o = out_char_q;
  assign last_o        = out_last_q;

endmodule

`default_nettype wire

@@ design/playfair_digraph_encryptor.sv @@
// Playfair digraph encryptor, top level. One beat is taken at a time; a pair
// is done before the next beat. Key done runs the fill sequencer, one letter of
// the alphabet per cycle. A completed pair reads both letter positions from the
// position RAM in turn, applies the rule, then reads the two cipher letters
// from the square RAM in turn (one read port each); output stalls hold the pair.
// Reset clears control state; square contents are rebuilt by the next key.
`default_nettype none

module playfair_digraph_encryptor (
  input  logic       clk_i,
  input  logic       rst_ni,
  pfe_in_if.sink     in_i,
  pfe_out_if.source  out_o
);
  import pfe_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;
  logic      in_ready;

  pfe_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .sts_i      (sts),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  pfe_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (in_i.op),
    .char_in_i     (in_i.char_in),
    .out_ready_i   (out_o.ready),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_o.valid),
    .cipher_char_o (out_o.cipher_char),
    .last_o        (out_o.last)
  );

  assign in_i.ready = in_ready;

endmodule

`default_nettype wire

@@ design/pfe_checker.sv @@
// Port-level checks for the Playfair encryptor, bound to the top level.
// Depends on pfe_pkg.
`default_nettype none

module pfe_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [6:0] cipher_char_i,
  input logic       last_i
);
  import pfe_pkg::*;

  logic second_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      second_q <= 1'b0;
    end else if (out_valid_i && out_ready_i) begin
      second_q <= !second_q;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(cipher_char_i) && $stable(last_i))
    else $error("output beat changed while stalled");

  a_letter_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ({1'b0, cipher_char_i} >= ASCII_A) && ({1'b0, cipher_char_i} <= ASCII_Z))
    else $error("cipher letter out of range");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i |-> last_i == second_q)
    else $error("digraph letters out of order");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while previous beat in progress");

  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared without a beat in progress");

endmodule

bind playfair_digraph_encryptor pfe_checker u_pfe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .cipher_char_i (out_o.cipher_char),
  .last_i        (out_o.last)
);

`default_nettype wire
